FILE: hw/rtl/blle_pkg.sv
`timescale 1ns / 1ps

package blle_pkg;

	localparam int CAPACITY_DEF = 16;

	typedef enum logic [2:0] {
		OP_INS_TAIL  = 3'd0,
		OP_INS_HEAD  = 3'd1,
		OP_INS_AFTER = 3'd2,
		OP_DEL_HEAD  = 3'd3,
		OP_DEL_TAIL  = 3'd4,
		OP_DEL_VALUE = 3'd5,
		OP_DUMP      = 3'd6,
		OP_COUNT     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_TAIL,
		S_INS_HEAD,
		S_LINK,
		S_WALK_POS,
		S_DEL_HEAD,
		S_WALK_TAIL,
		S_WALK_VAL,
		S_DUMP,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic [4:0]         position;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic [4:0]         node_count;
		logic               last;
	} rsp_item_t;

endpackage

FILE: hw/rtl/bounded_linked_list_engine_unit.sv
// Bounded singly linked list of up to CAPACITY signed 32-bit values. Nodes live in two
// synchronous RAMs (values and next-links, one read a cycle, registered read data); a used
// map in flops picks the lowest free slot for each new node. One request is in flight at a
// time; the next request is taken as soon as the engine is back in idle, which it enters at
// the edge that loads its last result, even while that result still sits in the output
// register. Count goes straight to its result; insert head, delete head, insert tail on an
// empty list and the errors seen at once (full, empty list) pass through their working state
// only; insert tail on a non-empty list adds the link patch state; insert after position p
// (0 counts as 1) walks to node p, or reports not found when the list ends first (the walk
// follows one link a cycle); delete tail walks to the last node; delete value walks to the
// first match or to the end of the list; dump loads one result per node per cycle from the
// first cycle on while rsp_stall is low. The link walk through the link RAM read port sets
// the worst case (delete value with no match on a full list). The node RAMs are not
// cleared: only slots that belong to the list are ever used, so the engine is ready
// straight after reset.
`timescale 1ns / 1ps

module bounded_linked_list_engine_unit
	import blle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	// index width holds the null code (CAPACITY); address width covers the slots only
	localparam int IW    = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);
	localparam int DEPTH = 1 << AW;
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	// ---------------------------------------------------------------------------------
	// control and list registers
	// ---------------------------------------------------------------------------------
	fsm_t                 state_q, state_d;
	logic [IW-1:0]        head_q, head_d;
	logic [IW-1:0]        tail_q, tail_d;
	logic [IW-1:0]        count_q, count_d;
	logic [CAPACITY-1:0]  used_q, used_d;

	// walk pointers: cur_q is the node whose RAM words are on the read data this cycle
	logic [IW-1:0]        cur_q, cur_d;
	logic [IW-1:0]        prev_q, prev_d;
	logic [4:0]           step_q, step_d;
	logic signed [31:0]   val_q, val_d;

	// pending single result, and the deferred link patch for two-write inserts
	status_t              res_status_q, res_status_d;
	logic signed [31:0]   res_value_q, res_value_d;
	logic [IW-1:0]        lk_addr_q, lk_addr_d;
	logic [IW-1:0]        new_q, new_d;

	// output register
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;
	logic                 out_free;
	logic                 out_load;
	rsp_item_t            out_data;

	// node RAMs
	logic signed [31:0]   value_mem [DEPTH];
	logic [IW-1:0]        link_mem  [DEPTH];
	logic [AW-1:0]        rd_addr;
	logic signed [31:0]   val_rd;
	logic [IW-1:0]        link_rd;

	logic                 vm_we;
	logic [AW-1:0]        vm_addr;
	logic signed [31:0]   vm_wdata;
	logic                 lm_we;
	logic [AW-1:0]        lm_addr;
	logic [IW-1:0]        lm_wdata;

	logic [IW-1:0]        free_idx;
	logic                 full;
	logic                 cur_nil;
	logic                 next_nil;

	// lowest free slot
	always_comb begin
		free_idx = NIL;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign full     = (count_q >= NIL);
	assign cur_nil  = (cur_q >= NIL);
	assign next_nil = (link_rd >= NIL);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// read address follows the next walk pointer, so data lines up with cur_q
	assign rd_addr = cur_d[AW-1:0];

	always_ff @(posedge clk) begin
		if (vm_we) begin
			value_mem[vm_addr] <= vm_wdata;
		end
		val_rd <= value_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (lm_we) begin
			link_mem[lm_addr] <= lm_wdata;
		end
		link_rd <= link_mem[rd_addr];
	end

	// ---------------------------------------------------------------------------------
	// sequencer: next state, list updates, RAM writes and result transfers
	// ---------------------------------------------------------------------------------
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		used_d       = used_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		step_d       = step_q;
		val_d        = val_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		lk_addr_d    = lk_addr_q;
		new_d        = new_q;
		vm_we        = 1'b0;
		vm_addr      = free_idx[AW-1:0];
		vm_wdata     = val_q;
		lm_we        = 1'b0;
		lm_addr      = free_idx[AW-1:0];
		lm_wdata     = NIL;
		out_load     = 1'b0;
		out_data     = '{status: STAT_OK, item_value: res_value_q,
		                 node_count: 5'(count_q), last: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				cur_d  = head_q;
				prev_d = NIL;
				if (req_valid) begin
					val_d        = req.value;
					step_d       = (req.position == 5'd0) ? 5'd0 : req.position - 5'd1;
					res_status_d = STAT_OK;
					res_value_d  = '0;
					unique case (op_t'(req.op))
						OP_INS_TAIL:  state_d = S_INS_TAIL;
						OP_INS_HEAD:  state_d = S_INS_HEAD;
						OP_INS_AFTER: state_d = S_WALK_POS;
						OP_DEL_HEAD:  state_d = S_DEL_HEAD;
						OP_DEL_TAIL:  state_d = S_WALK_TAIL;
						OP_DEL_VALUE: state_d = S_WALK_VAL;
						OP_DUMP:      state_d = S_DUMP;
						OP_COUNT:     state_d = S_EMIT;
						default:      state_d = S_EMIT;
					endcase
				end
			end

			S_INS_TAIL: begin
				if (full) begin
					res_status_d = STAT_FULL;
					state_d      = S_EMIT;
				end else begin
					vm_we                   = 1'b1;
					lm_we                   = 1'b1;
					lm_wdata                = NIL;
					used_d[free_idx[AW-1:0]] = 1'b1;
					count_d                 = count_q + 1'b1;
					tail_d                  = free_idx;
					if (head_q >= NIL) begin
						head_d  = free_idx;
						state_d = S_EMIT;
					end else begin
						lk_addr_d = tail_q;
						new_d     = free_idx;
						state_d   = S_LINK;
					end
				end
			end

			S_INS_HEAD: begin
				if (full) begin
					res_status_d = STAT_FULL;
				end else begin
					vm_we                   = 1'b1;
					lm_we                   = 1'b1;
					lm_wdata                = head_q;
					used_d[free_idx[AW-1:0]] = 1'b1;
					count_d                 = count_q + 1'b1;
					head_d                  = free_idx;
					if (tail_q >= NIL) begin
						tail_d = free_idx;
					end
				end
				state_d = S_EMIT;
			end

			// second link write of a tail or mid-list insert
			S_LINK: begin
				lm_we    = 1'b1;
				lm_addr  = lk_addr_q[AW-1:0];
				lm_wdata = new_q;
				state_d  = S_EMIT;
			end

			S_WALK_POS: begin
				if (full) begin
					res_status_d = STAT_FULL;
					state_d      = S_EMIT;
				end else if (cur_nil) begin
					res_status_d = STAT_NOT_FOUND;
					state_d      = S_EMIT;
				end else if (step_q == 5'd0) begin
					vm_we                   = 1'b1;
					lm_we                   = 1'b1;
					lm_wdata                = link_rd;
					used_d[free_idx[AW-1:0]] = 1'b1;
					count_d                 = count_q + 1'b1;
					if (cur_q == tail_q) begin
						tail_d = free_idx;
					end
					lk_addr_d = cur_q;
					new_d     = free_idx;
					state_d   = S_LINK;
				end else if (next_nil) begin
					res_status_d = STAT_NOT_FOUND;
					state_d      = S_EMIT;
				end else begin
					cur_d  = link_rd;
					step_d = step_q - 5'd1;
				end
			end

			S_DEL_HEAD: begin
				if (cur_nil) begin
					res_status_d = STAT_EMPTY;
				end else begin
					head_d = link_rd;
					if (next_nil) begin
						tail_d = NIL;
					end
					used_d[cur_q[AW-1:0]] = 1'b0;
					count_d              = count_q - 1'b1;
					res_value_d          = val_rd;
				end
				state_d = S_EMIT;
			end

			S_WALK_TAIL: begin
				if (cur_nil) begin
					res_status_d = STAT_EMPTY;
					state_d      = S_EMIT;
				end else if (next_nil) begin
					if (prev_q >= NIL) begin
						head_d = NIL;
						tail_d = NIL;
					end else begin
						lm_we    = 1'b1;
						lm_addr  = prev_q[AW-1:0];
						lm_wdata = NIL;
						tail_d   = prev_q;
					end
					used_d[cur_q[AW-1:0]] = 1'b0;
					count_d              = count_q - 1'b1;
					res_value_d          = val_rd;
					state_d              = S_EMIT;
				end else begin
					prev_d = cur_q;
					cur_d  = link_rd;
				end
			end

			S_WALK_VAL: begin
				if (cur_nil) begin
					res_status_d = STAT_NOT_FOUND;
					state_d      = S_EMIT;
				end else if (val_rd == val_q) begin
					if (prev_q >= NIL) begin
						head_d = link_rd;
					end else begin
						lm_we    = 1'b1;
						lm_addr  = prev_q[AW-1:0];
						lm_wdata = link_rd;
					end
					if (cur_q == tail_q) begin
						tail_d = prev_q;
					end
					used_d[cur_q[AW-1:0]] = 1'b0;
					count_d              = count_q - 1'b1;
					res_value_d          = val_rd;
					state_d              = S_EMIT;
				end else begin
					prev_d = cur_q;
					cur_d  = link_rd;
				end
			end

			// one transfer per node; on a stall the same node is simply read again
			S_DUMP: begin
				if (cur_nil) begin
					res_status_d = STAT_EMPTY;
					state_d      = S_EMIT;
				end else if (out_free) begin
					out_load = 1'b1;
					out_data = '{status: STAT_OK, item_value: val_rd,
					             node_count: 5'(count_q), last: next_nil};
					cur_d    = link_rd;
					if (next_nil) begin
						state_d = S_IDLE;
					end
				end
			end

			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = '{status: res_status_q, item_value: res_value_q,
					             node_count: 5'(count_q), last: 1'b1};
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			count_q     <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			used_q  <= used_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		step_q       <= step_d;
		val_q        <= val_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		lk_addr_q    <= lk_addr_d;
		new_q        <= new_d;
		if (out_load) begin
			rsp_q <= out_data;
		end
	end

	// ---------------------------------------------------------------------------------
	// checks on list bookkeeping
	// ---------------------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL)
		else $error("element count above capacity");

	a_used_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("used map out of step with element count");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q >= NIL) == (count_q == '0))
		else $error("head pointer disagrees with element count");

	a_tail_head: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q >= NIL) == (head_q >= NIL))
		else $error("tail and head disagree on empty list");

endmodule

FILE: sim/tb_bounded_linked_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_bounded_linked_list_engine_unit;
	import blle_pkg::*;

	localparam int         CAP       = CAPACITY_DEF;
	localparam logic [4:0] NIL       = 5'(CAP);
	localparam int         HOLD_OFF  = 250;   // long receiver hold-off, in cycles
	localparam int         SETTLE    = 60;    // above the worst-case engine latency

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// shadow of the list held by the engine
	logic signed [31:0] node_val  [CAP];
	logic [4:0]         node_next [CAP];
	logic [CAP-1:0]     slot_used = '0;
	logic [4:0]         head_idx  = NIL;
	logic [4:0]         tail_idx  = NIL;
	int                 list_len  = 0;

	rsp_item_t list_results_due[$];
	int        mismatch_count = 0;
	int        burst_left     = 0;
	bit        hold_off_req   = 1'b0;

	bounded_linked_list_engine_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("bounded_linked_list_engine_unit verification failed");
		$finish;
	end

	function automatic logic [4:0] next_of(input logic [4:0] n);
		if (n >= NIL)
			return NIL;
		return (node_next[n] < NIL) ? node_next[n] : NIL;
	endfunction

	function automatic logic [4:0] lowest_free();
		for (int i = 0; i < CAP; i++)
			if (!slot_used[i])
				return 5'(i);
		return NIL;
	endfunction

	function automatic logic signed [31:0] listed_value();
		logic [4:0] walk;
		int         hops;
		walk = head_idx;
		hops = $urandom_range(0, list_len - 1);
		repeat (hops) walk = next_of(walk);
		return node_val[walk];
	endfunction

	function automatic req_item_t make_req(input op_t o, input logic signed [31:0] v,
			input logic [4:0] p);
		req_item_t r;
		r.op       = o;
		r.value    = v;
		r.position = p;
		return r;
	endfunction

	// node_count always reflects the list length after the operation
	task automatic due_result(input status_t st, input logic signed [31:0] v,
			input logic is_last);
		rsp_item_t r;
		r.status     = st;
		r.item_value = v;
		r.node_count = list_len[4:0];
		r.last       = is_last;
		list_results_due.push_back(r);
	endtask

	task automatic release_slot(input logic [4:0] n);
		slot_used[n] = 1'b0;
		list_len--;
	endtask

	// Apply one request to the shadow list and queue the results it must give
	task automatic predict_list_op(input req_item_t r);
		logic [4:0] slot, walk, prior;
		int         pos, steps;
		case (r.op)
			OP_INS_TAIL, OP_INS_HEAD: begin
				if (list_len >= CAP) begin
					due_result(STAT_FULL, 0, 1'b1);
				end else begin
					slot = lowest_free();
					slot_used[slot] = 1'b1;
					node_val[slot]  = r.value;
					if (r.op == OP_INS_TAIL) begin
						node_next[slot] = NIL;
						if (head_idx == NIL)
							head_idx = slot;
						else
							node_next[tail_idx] = slot;
						tail_idx = slot;
					end else begin
						node_next[slot] = head_idx;
						head_idx = slot;
						if (tail_idx == NIL)
							tail_idx = slot;
					end
					list_len++;
					due_result(STAT_OK, 0, 1'b1);
				end
			end
			OP_INS_AFTER: begin
				// full is reported before the position is looked for
				if (list_len >= CAP) begin
					due_result(STAT_FULL, 0, 1'b1);
				end else begin
					pos  = (r.position == 0) ? 1 : int'(r.position);
					walk = head_idx;
					for (steps = 1; steps < pos && walk != NIL; steps++)
						walk = next_of(walk);
					if (walk == NIL) begin
						due_result(STAT_NOT_FOUND, 0, 1'b1);
					end else begin
						slot = lowest_free();
						slot_used[slot] = 1'b1;
						node_val[slot]  = r.value;
						node_next[slot] = next_of(walk);
						node_next[walk] = slot;
						if (walk == tail_idx)
							tail_idx = slot;
						list_len++;
						due_result(STAT_OK, 0, 1'b1);
					end
				end
			end
			OP_DEL_HEAD: begin
				if (head_idx == NIL) begin
					due_result(STAT_EMPTY, 0, 1'b1);
				end else begin
					walk     = head_idx;
					head_idx = next_of(walk);
					if (head_idx == NIL)
						tail_idx = NIL;
					release_slot(walk);
					due_result(STAT_OK, node_val[walk], 1'b1);
				end
			end
			OP_DEL_TAIL: begin
				if (head_idx == NIL) begin
					due_result(STAT_EMPTY, 0, 1'b1);
				end else begin
					prior = NIL;
					walk  = head_idx;
					for (steps = 0; steps < CAP && next_of(walk) != NIL; steps++) begin
						prior = walk;
						walk  = next_of(walk);
					end
					if (prior == NIL) begin
						head_idx = NIL;
						tail_idx = NIL;
					end else begin
						node_next[prior] = NIL;
						tail_idx = prior;
					end
					release_slot(walk);
					due_result(STAT_OK, node_val[walk], 1'b1);
				end
			end
			OP_DEL_VALUE: begin
				prior = NIL;
				walk  = head_idx;
				for (steps = 0; steps < CAP && walk != NIL && node_val[walk] != r.value;
						steps++) begin
					prior = walk;
					walk  = next_of(walk);
				end
				if (walk == NIL) begin
					due_result(STAT_NOT_FOUND, 0, 1'b1);
				end else begin
					if (prior == NIL)
						head_idx = next_of(walk);
					else
						node_next[prior] = next_of(walk);
					if (walk == tail_idx)
						tail_idx = prior;
					release_slot(walk);
					due_result(STAT_OK, node_val[walk], 1'b1);
				end
			end
			OP_DUMP: begin
				if (head_idx == NIL) begin
					due_result(STAT_EMPTY, 0, 1'b1);
				end else begin
					walk = head_idx;
					for (steps = 0; steps < CAP && walk != NIL; steps++) begin
						due_result(STAT_OK, node_val[walk], next_of(walk) == NIL);
						walk = next_of(walk);
					end
				end
			end
			default: due_result(STAT_OK, 0, 1'b1);
		endcase
	endtask

	// Offer one request from a rising edge and return at the edge that takes it, or
	// after the random gap that may end a burst. Conditions are read at the falling edge so
	// the outcome never hinges on event order at the rising edge.
	task automatic send_request(input req_item_t item);
		int gap;
		req       <= item;
		req_valid <= 1'b1;
		do
			@(negedge clk);
		while (req_stall);
		predict_list_op(item);
		@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(10, 25);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// Result check: each transfer against the oldest result due
	task automatic report_mismatch(input string what, input rsp_item_t want,
			input rsp_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected status=%0d value=%0d count=%0d last=%0b, got status=%0d value=%0d count=%0d last=%0b",
				$time, what, want.status, want.item_value, want.node_count, want.last,
				got.status, got.item_value, got.node_count, got.last);
	endtask

	always @(negedge clk) begin : result_check
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (list_results_due.size() == 0) begin
				report_mismatch("result with none due", '0, rsp);
			end else begin
				want = list_results_due.pop_front();
				if (rsp.status !== want.status || rsp.item_value !== want.item_value ||
						rsp.node_count !== want.node_count || rsp.last !== want.last)
					report_mismatch("result mismatch", want, rsp);
			end
		end
	end

	// Receiver stall pattern; a requested hold-off takes priority
	initial begin : rsp_stall_pattern
		stall_mode_t mode;
		int          mode_left;
		int          hold_left;
		mode      = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  rsp_stall <= 1'b0;
					STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
					default:     rsp_stall <= (mode_left % 3 == 0);
				endcase
			end
		end
	end

	// Every delete, dump, count and position insert on an empty list
	task automatic test_empty_list();
		send_request(make_req(OP_DEL_HEAD, 0, 5'd0));
		send_request(make_req(OP_DEL_TAIL, 0, 5'd0));
		send_request(make_req(OP_DEL_VALUE, 0, 5'd0));
		send_request(make_req(OP_DUMP, 0, 5'd0));
		send_request(make_req(OP_COUNT, 0, 5'd0));
		send_request(make_req(OP_INS_AFTER, 32'sd7, 5'd1));
	endtask

	// Extreme values, position zero, insert after tail, missing positions,
	// duplicate values and deletes at both ends
	task automatic test_edge_inserts();
		send_request(make_req(OP_INS_TAIL, 32'sh7FFF_FFFF, 5'd0));
		send_request(make_req(OP_INS_HEAD, 32'sh8000_0000, 5'd0));
		send_request(make_req(OP_INS_AFTER, -32'sd1, 5'd0));
		send_request(make_req(OP_INS_AFTER, 32'sd0, 5'd3));
		send_request(make_req(OP_INS_AFTER, 32'sd5, 5'd16));
		send_request(make_req(OP_INS_AFTER, 32'sd5, 5'd5));
		send_request(make_req(OP_INS_TAIL, 32'sd0, 5'd0));
		send_request(make_req(OP_DUMP, 0, 5'd0));
		send_request(make_req(OP_DEL_VALUE, 32'sd0, 5'd0));
		send_request(make_req(OP_DEL_VALUE, 32'sd12345, 5'd0));
		send_request(make_req(OP_DEL_VALUE, 32'sh8000_0000, 5'd0));
		send_request(make_req(OP_DEL_TAIL, 0, 5'd0));
		send_request(make_req(OP_DEL_VALUE, 32'sh7FFF_FFFF, 5'd0));
		send_request(make_req(OP_DEL_HEAD, 0, 5'd0));
		send_request(make_req(OP_COUNT, 0, 5'd0));
	endtask

	// Fill the list while the receiver holds off so the engine backs up,
	// then hit full on each kind of insert and dump the longest list
	task automatic test_fill_under_hold_off();
		int fill;
		fill = CAP - list_len;
		hold_off_req = 1'b1;
		for (int i = 0; i < fill; i++)
			send_request(make_req(OP_INS_TAIL, $urandom, 5'($urandom_range(0, 16))));
		send_request(make_req(OP_INS_HEAD, $urandom, 5'd0));
		send_request(make_req(OP_INS_AFTER, $urandom, 5'd16));
		send_request(make_req(OP_INS_TAIL, $urandom, 5'd0));
		send_request(make_req(OP_DUMP, 0, 5'd0));
		send_request(make_req(OP_DEL_TAIL, 0, 5'd0));
		send_request(make_req(OP_INS_AFTER, 32'sd3, 5'd16));
		send_request(make_req(OP_COUNT, 0, 5'd0));
	endtask

	// Random traffic drifting between growing and shrinking phases so the
	// list swings between empty and full; values often repeat or match
	task automatic test_random_traffic();
		int                 phase_left;
		int                 roll;
		bit                 growing;
		op_t                o;
		logic signed [31:0] v;
		logic [4:0]         p;
		phase_left = 0;
		growing    = 1'b1;
		for (int n = 0; n < 106; n++) begin
			if (phase_left == 0) begin
				growing    = !growing;
				phase_left = $urandom_range(15, 40);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (growing) begin
				if      (roll < 30) o = OP_INS_TAIL;
				else if (roll < 50) o = OP_INS_HEAD;
				else if (roll < 70) o = OP_INS_AFTER;
				else if (roll < 75) o = OP_DEL_HEAD;
				else if (roll < 80) o = OP_DEL_TAIL;
				else if (roll < 88) o = OP_DEL_VALUE;
				else if (roll < 95) o = OP_DUMP;
				else                o = OP_COUNT;
			end else begin
				if      (roll < 10) o = OP_INS_TAIL;
				else if (roll < 15) o = OP_INS_HEAD;
				else if (roll < 20) o = OP_INS_AFTER;
				else if (roll < 40) o = OP_DEL_HEAD;
				else if (roll < 60) o = OP_DEL_TAIL;
				else if (roll < 80) o = OP_DEL_VALUE;
				else if (roll < 92) o = OP_DUMP;
				else                o = OP_COUNT;
			end
			roll = $urandom_range(0, 9);
			if (roll < 4 && list_len > 0)
				v = listed_value();
			else if (roll < 7)
				v = $signed($urandom_range(0, 7)) - 4;
			else
				v = $urandom;
			if ($urandom_range(0, 9) < 7)
				p = 5'($urandom_range(0, (list_len + 1 > 16) ? 16 : list_len + 1));
			else
				p = 5'($urandom_range(0, 16));
			send_request(make_req(o, v, p));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edge_inserts();
		test_fill_under_hold_off();
		test_random_traffic();
		req_valid <= 1'b0;
		while (list_results_due.size() != 0)
			@(posedge clk);
		// catch any stray transfer after the last expected one
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("bounded_linked_list_engine_unit verification clean");
		else
			$display("bounded_linked_list_engine_unit verification failed");
		$finish;
	end

endmodule
